FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define LSM_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define LSM_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/lsm_pkg.sv
// Shared widths, constants and the arctangent table for the lattice step unit.
package lsm_pkg;

  // Field widths
  localparam int G_W     = 32;             // metric term
  localparam int N_W     = 18;             // 2*(1-mm) numerator, Q0.16 times two
  localparam int QD_W    = N_W + G_W;      // quotient fed to the root
  localparam int ROOT_W  = QD_W / 2;       // root width
  localparam int MAG_W   = 17;             // angle magnitude
  localparam int ANG_W   = 33;             // residual angle, Q2.30
  localparam int XY_W    = 34;             // rotation vector
  localparam int STEP_W  = 32;

  localparam logic [15:0]      MM_RESET   = 16'd63570;
  localparam logic [17:0]      HALF_PI_Q16 = 18'd102943;
  localparam logic [XY_W-1:0]  GAIN_Q30   = 34'd652032874;

  // Register map
  typedef enum logic {
    REG_MINIMAL_MATCH = 1'b0
  } reg_index_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic [ANG_W-1:0] atan_q30(input int i);
    logic [ANG_W-1:0] t;
    case (i)
      0:  t = 33'd843314856;
      1:  t = 33'd497837829;
      2:  t = 33'd263043836;
      3:  t = 33'd133525158;
      4:  t = 33'd67021686;
      5:  t = 33'd33543515;
      6:  t = 33'd16775850;
      7:  t = 33'd8388437;
      8:  t = 33'd4194282;
      9:  t = 33'd2097149;
      10: t = 33'd1048575;
      11: t = 33'd524287;
      12: t = 33'd262143;
      13: t = 33'd131071;
      14: t = 33'd65535;
      15: t = 33'd32767;
      16: t = 33'd16383;
      17: t = 33'd8191;
      18: t = 33'd4095;
      19: t = 33'd2047;
      20: t = 33'd1023;
      21: t = 33'd511;
      22: t = 33'd255;
      23: t = 33'd127;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

FILE: hw/rtl/lsm_cordic_cell.sv
// One rotation step of the sine/cosine chain, with its carried word.
module lsm_cordic_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [lsm_pkg::XY_W-1:0]  x_in,
  input  logic signed [lsm_pkg::XY_W-1:0]  y_in,
  input  logic signed [lsm_pkg::ANG_W-1:0] z_in,
  input  logic [SIDE_W-1:0]                side_in,
  output logic signed [lsm_pkg::XY_W-1:0]  x,
  output logic signed [lsm_pkg::XY_W-1:0]  y,
  output logic signed [lsm_pkg::ANG_W-1:0] z,
  output logic [SIDE_W-1:0]                side
);
  import lsm_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN_T = atan_q30(STEP);

  logic signed [XY_W-1:0]  x_next;
  logic signed [XY_W-1:0]  y_next;
  logic signed [ANG_W-1:0] z_next;

  // Rotate toward zero residual angle
  always_comb begin
    if (!z_in[ANG_W-1]) begin
      x_next = x_in - (y_in >>> STEP);
      y_next = y_in + (x_in >>> STEP);
      z_next = z_in - ATAN_T;
    end else begin
      x_next = x_in + (y_in >>> STEP);
      y_next = y_in - (x_in >>> STEP);
      z_next = z_in + ATAN_T;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      side <= side_in;
    end
  end

endmodule

FILE: hw/rtl/lsm_div_cell.sv
// One bit of a restoring long division, with its carried word.
module lsm_div_cell #(
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [DEN_W+NUM_W-1:0] acc_in,
  input  logic [DEN_W-1:0]       den_in,
  input  logic [SIDE_W-1:0]      side_in,
  output logic [DEN_W+NUM_W-1:0] acc,
  output logic [DEN_W-1:0]       den,
  output logic [SIDE_W-1:0]      side
);

  logic [DEN_W+NUM_W:0]   shifted;
  logic [DEN_W:0]         upper;
  logic [DEN_W:0]         diff;
  logic [DEN_W+NUM_W-1:0] acc_next;

  // Shift in one numerator bit, subtract the divisor where it fits
  always_comb begin
    shifted = {acc_in, 1'b0};
    upper   = shifted[DEN_W+NUM_W:NUM_W];
    diff    = upper - {1'b0, den_in};
    if (upper >= {1'b0, den_in}) begin
      acc_next = {diff[DEN_W-1:0], shifted[NUM_W-1:1], 1'b1};
    end else begin
      acc_next = shifted[DEN_W+NUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc  <= acc_next;
      den  <= den_in;
      side <= side_in;
    end
  end

endmodule

FILE: hw/rtl/lsm_sqrt_cell.sv
// One digit of a bit-pair integer square root, with its carried word.
module lsm_sqrt_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [lsm_pkg::ROOT_W+1:0]   rem_in,
  input  logic [lsm_pkg::ROOT_W-1:0]   root_in,
  input  logic [lsm_pkg::QD_W-1:0]     rad_in,
  input  logic [SIDE_W-1:0]            side_in,
  output logic [lsm_pkg::ROOT_W+1:0]   rem,
  output logic [lsm_pkg::ROOT_W-1:0]   root,
  output logic [lsm_pkg::QD_W-1:0]     rad,
  output logic [SIDE_W-1:0]            side
);
  import lsm_pkg::*;

  logic [ROOT_W+3:0] r2;
  logic [ROOT_W+3:0] trial;
  logic [ROOT_W+3:0] diff;
  logic [ROOT_W+1:0] rem_next;
  logic [ROOT_W-1:0] root_next;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    r2    = {rem_in, rad_in[QD_W-1:QD_W-2]};
    trial = {2'b00, root_in, 2'b01};
    diff  = r2 - trial;
    if (r2 >= trial) begin
      rem_next  = diff[ROOT_W+1:0];
      root_next = {root_in[ROOT_W-2:0], 1'b1};
    end else begin
      rem_next  = r2[ROOT_W+1:0];
      root_next = {root_in[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= rem_next;
      root <= root_next;
      rad  <= {rad_in[QD_W-3:0], 2'b00};
      side <= side_in;
    end
  end

endmodule

FILE: hw/rtl/lattice_step_from_metric_unit.sv
// Top level: lattice step spacings from two metric terms and a tilt angle.
//
//  channel  | direction | handshake                  | payload
//  item     | in        | item_valid / item_stall    | metric_first, metric_second, tilt_angle
//  result   | out       | result_valid / result_stall| step_along, step_across, fault
//  config   | in        | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One word enters per cycle while no stalled result holds the chain; a word passes the rotation cells, the
// quotient chains, the root chains, the region registers, the along-step division chain and the output register.
// Synchronous reset clears the valid line and loads minimal_match with its default.
// A stalled result freezes the whole chain of cells; the input stalls only then.
`include "assert_macros.svh"

module lattice_step_from_metric_unit #(
  parameter int FRAC_BITS      = 16,
  parameter int ROTATION_STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // items
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [lsm_pkg::G_W-1:0]     metric_first,
  input  logic [lsm_pkg::G_W-1:0]     metric_second,
  input  logic signed [17:0]          tilt_angle,
  // results
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [lsm_pkg::STEP_W-1:0]  step_along,
  output logic [lsm_pkg::STEP_W-1:0]  step_across,
  output logic                        fault
);
  import lsm_pkg::*;

  localparam int TRIG_W  = FRAC_BITS + 1;
  localparam int NUM2_W  = ROOT_W + FRAC_BITS;
  localparam int PROD_W  = ROOT_W + TRIG_W;
  localparam int COR_SIDE_W = 2 * G_W + 2;
  localparam int TOTAL   = ROTATION_STEPS + QD_W + ROOT_W + 2 + NUM2_W + 1;

  logic adv;
  logic [TOTAL-1:0] vld;
  logic [15:0] minimal_match;
  logic cfg_write;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      minimal_match <= MM_RESET;
    end else if (cfg_write && (paddr[2] == REG_MINIMAL_MATCH)) begin
      minimal_match <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_MINIMAL_MATCH) ? {16'b0, minimal_match} : 32'b0;

  // Global advance: hold everything while the result word waits
  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOTAL-2:0], item_valid};
    end
  end

  assign result_valid = vld[TOTAL-1];

  // Input checks and angle magnitude
  logic [17:0] mag_full;
  logic        in_fault;
  logic        in_zero;

  always_comb begin
    mag_full = tilt_angle[17] ? 18'(-tilt_angle) : tilt_angle;
    in_fault = (metric_first == '0) || (metric_second == '0) ||
               (mag_full > HALF_PI_Q16) || (minimal_match == '0);
    in_zero  = (mag_full == '0);
  end

  // Rotation chain
  logic signed [XY_W-1:0]  cx [0:ROTATION_STEPS];
  logic signed [XY_W-1:0]  cy [0:ROTATION_STEPS];
  logic signed [ANG_W-1:0] cz [0:ROTATION_STEPS];
  logic [COR_SIDE_W-1:0]   cs [0:ROTATION_STEPS];

  assign cx[0] = GAIN_Q30;
  assign cy[0] = '0;
  assign cz[0] = ANG_W'({mag_full[MAG_W-1:0], 14'b0});
  assign cs[0] = {metric_first, metric_second, in_fault, in_zero};

  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_cordic
    lsm_cordic_cell #(.STEP(i), .SIDE_W(COR_SIDE_W)) u_cell (
      .clk(clk), .en(adv),
      .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]), .side_in(cs[i]),
      .x(cx[i+1]), .y(cy[i+1]), .z(cz[i+1]), .side(cs[i+1])
    );
  end

  // Truncate to Q1.FRAC_BITS, clamp negatives, exact values at zero angle
  logic [TRIG_W-1:0] cos_v;
  logic [TRIG_W-1:0] sin_v;
  logic [G_W-1:0]    g0_c;
  logic [G_W-1:0]    g1_c;
  logic              fault_c;
  logic              zero_c;
  logic signed [XY_W-1:0] xe;
  logic signed [XY_W-1:0] ye;

  always_comb begin
    xe = cx[ROTATION_STEPS];
    ye = cy[ROTATION_STEPS];
    {g0_c, g1_c, fault_c, zero_c} = cs[ROTATION_STEPS];
    if (zero_c) begin
      cos_v = TRIG_W'(1) << FRAC_BITS;
      sin_v = '0;
    end else begin
      cos_v = (!xe[XY_W-1] && (xe != '0)) ? xe[30 -: TRIG_W] : '0;
      sin_v = (!ye[XY_W-1] && (ye != '0)) ? ye[30 -: TRIG_W] : '0;
    end
  end

  // Quotient chains: floor(n * 2^32 / g)
  localparam int D1_W = G_W + QD_W;
  logic [N_W-1:0]     num_n;
  logic [D1_W-1:0]    da_acc [0:QD_W];
  logic [G_W-1:0]     da_den [0:QD_W];
  logic [2*TRIG_W-1:0] da_side [0:QD_W];
  logic [D1_W-1:0]    db_acc [0:QD_W];
  logic [G_W-1:0]     db_den [0:QD_W];
  logic               db_side [0:QD_W];

  assign num_n      = {17'(17'h10000 - {1'b0, minimal_match}), 1'b0};
  assign da_acc[0]  = {{G_W{1'b0}}, num_n, {G_W{1'b0}}};
  assign da_den[0]  = g0_c;
  assign da_side[0] = {cos_v, sin_v};
  assign db_acc[0]  = {{G_W{1'b0}}, num_n, {G_W{1'b0}}};
  assign db_den[0]  = g1_c;
  assign db_side[0] = fault_c;

  for (genvar i = 0; i < QD_W; i++) begin : g_div
    lsm_div_cell #(.NUM_W(QD_W), .DEN_W(G_W), .SIDE_W(2*TRIG_W)) u_a (
      .clk(clk), .en(adv),
      .acc_in(da_acc[i]), .den_in(da_den[i]), .side_in(da_side[i]),
      .acc(da_acc[i+1]), .den(da_den[i+1]), .side(da_side[i+1])
    );
    lsm_div_cell #(.NUM_W(QD_W), .DEN_W(G_W), .SIDE_W(1)) u_b (
      .clk(clk), .en(adv),
      .acc_in(db_acc[i]), .den_in(db_den[i]), .side_in(db_side[i]),
      .acc(db_acc[i+1]), .den(db_den[i+1]), .side(db_side[i+1])
    );
  end

  // Root chains
  logic [ROOT_W+1:0]   ra_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]   ra_root [0:ROOT_W];
  logic [QD_W-1:0]     ra_rad  [0:ROOT_W];
  logic [2*TRIG_W-1:0] ra_side [0:ROOT_W];
  logic [ROOT_W+1:0]   rb_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]   rb_root [0:ROOT_W];
  logic [QD_W-1:0]     rb_rad  [0:ROOT_W];
  logic                rb_side [0:ROOT_W];

  assign ra_rem[0]  = '0;
  assign ra_root[0] = '0;
  assign ra_rad[0]  = da_acc[QD_W][QD_W-1:0];
  assign ra_side[0] = da_side[QD_W];
  assign rb_rem[0]  = '0;
  assign rb_root[0] = '0;
  assign rb_rad[0]  = db_acc[QD_W][QD_W-1:0];
  assign rb_side[0] = db_side[QD_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    lsm_sqrt_cell #(.SIDE_W(2*TRIG_W)) u_a (
      .clk(clk), .en(adv),
      .rem_in(ra_rem[i]), .root_in(ra_root[i]), .rad_in(ra_rad[i]), .side_in(ra_side[i]),
      .rem(ra_rem[i+1]), .root(ra_root[i+1]), .rad(ra_rad[i+1]), .side(ra_side[i+1])
    );
    lsm_sqrt_cell #(.SIDE_W(1)) u_b (
      .clk(clk), .en(adv),
      .rem_in(rb_rem[i]), .root_in(rb_root[i]), .rad_in(rb_rad[i]), .side_in(rb_side[i]),
      .rem(rb_rem[i+1]), .root(rb_root[i+1]), .rad(rb_rad[i+1]), .side(rb_side[i+1])
    );
  end

  // Region test products
  logic [PROD_W-1:0] p_sa;
  logic [PROD_W-1:0] p_cb;
  logic [ROOT_W-1:0] p_a;
  logic [ROOT_W-1:0] p_b;
  logic [TRIG_W-1:0] p_c;
  logic [TRIG_W-1:0] p_s;
  logic              p_fault;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_a     <= ra_root[ROOT_W];
      p_b     <= rb_root[ROOT_W];
      p_c     <= ra_side[ROOT_W][2*TRIG_W-1:TRIG_W];
      p_s     <= ra_side[ROOT_W][TRIG_W-1:0];
      p_sa    <= PROD_W'(ra_side[ROOT_W][TRIG_W-1:0]) * PROD_W'(ra_root[ROOT_W]);
      p_cb    <= PROD_W'(ra_side[ROOT_W][2*TRIG_W-1:TRIG_W]) * PROD_W'(rb_root[ROOT_W]);
      p_fault <= rb_side[ROOT_W];
    end
  end

  // Pick the region, form the across step
  logic              first_region;
  logic [PROD_W-1:0] mul_v;
  logic [ROOT_W-1:0] s_num;
  logic [TRIG_W-1:0] s_den;
  logic [STEP_W-1:0] s_across;
  logic              s_fault;

  always_comb begin
    first_region = (p_sa <= p_cb);
    if (first_region) begin
      mul_v = PROD_W'(p_b) * PROD_W'(p_c);
    end else begin
      mul_v = PROD_W'(p_a) * PROD_W'(p_s);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_num    <= first_region ? p_a : p_b;
      s_den    <= first_region ? p_c : p_s;
      s_across <= STEP_W'(mul_v >> FRAC_BITS);
      s_fault  <= p_fault;
    end
  end

  // Along step division chain
  localparam int D2_W = TRIG_W + NUM2_W;
  logic [D2_W-1:0]     q_acc  [0:NUM2_W];
  logic [TRIG_W-1:0]   q_den  [0:NUM2_W];
  logic [STEP_W:0]     q_side [0:NUM2_W];

  assign q_acc[0]  = {{TRIG_W{1'b0}}, s_num, {FRAC_BITS{1'b0}}};
  assign q_den[0]  = s_den;
  assign q_side[0] = {s_across, s_fault};

  for (genvar i = 0; i < NUM2_W; i++) begin : g_div2
    lsm_div_cell #(.NUM_W(NUM2_W), .DEN_W(TRIG_W), .SIDE_W(STEP_W+1)) u_cell (
      .clk(clk), .en(adv),
      .acc_in(q_acc[i]), .den_in(q_den[i]), .side_in(q_side[i]),
      .acc(q_acc[i+1]), .den(q_den[i+1]), .side(q_side[i+1])
    );
  end

  // Output register: saturate the along step, zero on fault
  logic [NUM2_W-1:0] quo;
  logic              q_fault;
  logic [STEP_W-1:0] q_across;

  always_comb begin
    quo      = q_acc[NUM2_W][NUM2_W-1:0];
    q_across = q_side[NUM2_W][STEP_W:1];
    q_fault  = q_side[NUM2_W][0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fault <= q_fault;
      if (q_fault) begin
        step_along  <= '0;
        step_across <= '0;
      end else begin
        step_along  <= (|quo[NUM2_W-1:STEP_W]) ? {STEP_W{1'b1}} : quo[STEP_W-1:0];
        step_across <= q_across;
      end
    end
  end

  // Checks
  `LSM_CHECK(a_cfg_write, cfg_write && (paddr[2] == REG_MINIMAL_MATCH) |=> minimal_match == $past(pwdata[15:0]), "minimal_match not written")
  `LSM_CHECK(a_fault_zero, result_valid && fault |-> step_along == '0 && step_across == '0, "fault word with nonzero steps")
  `LSM_CHECK(a_hold_line, !adv |=> vld == $past(vld), "valid line moved while held")
  `LSM_CHECK_ALWAYS(a_reset_empty, rst |=> !result_valid, "result after reset")

endmodule

FILE: bench/lattice_step_from_metric_unit_tb.sv
// Self-checking bench for the lattice step unit: random and directed words, scoreboard check.
module lattice_step_from_metric_unit_tb;
  import lsm_pkg::*;

  typedef struct packed {
    logic [31:0] along;
    logic [31:0] across;
    logic        fault;
  } spacing_t;

  // Predicts lattice spacings and holds them until the unit delivers them
  class spacing_board;
    logic [15:0] mm;
    spacing_t pending[$];
    int errors;
    int checked;

    function new();
      mm = MM_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint asr(longint v, int s);
      if (v >= 0) return v >>> s;
      return -1 - ((-1 - v) >>> s);
    endfunction

    function void rotate(longint mag, output logic [63:0] c, output logic [63:0] s);
      longint x;
      longint y;
      longint z;
      longint nx;
      longint t;
      x = GAIN_Q30;
      y = 0;
      z = mag <<< 14;
      if (mag == 0) begin
        c = 64'd1 << 16;
        s = 0;
        return;
      end
      for (int i = 0; i < 16; i++) begin
        t = longint'(atan_q30(i));
        if (z >= 0) begin
          nx = x - asr(y, i);
          y = y + asr(x, i);
          z = z - t;
        end else begin
          nx = x + asr(y, i);
          y = y - asr(x, i);
          z = z + t;
        end
        x = nx;
      end
      c = x > 0 ? 64'(x) >> 14 : 0;
      s = y > 0 ? 64'(y) >> 14 : 0;
    endfunction

    function logic [31:0] clip(logic [63:0] v);
      return v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function logic [31:0] div_step(logic [63:0] num, logic [63:0] den);
      if (den == 0) return 32'hFFFF_FFFF;
      return clip((num << 16) / den);
    endfunction

    // Note an accepted input word and queue its expected spacing
    function void note_item(logic [31:0] g0, logic [31:0] g1, logic signed [17:0] th);
      spacing_t e;
      longint mag;
      logic [63:0] n, a, b, c, s;
      mag = th < 0 ? -longint'(th) : longint'(th);
      e = '0;
      if (g0 == 0 || g1 == 0 || mag > HALF_PI_Q16 || mm == 0) begin
        e.fault = 1'b1;
      end else begin
        n = 2 * (64'd65536 - mm);
        a = isqrt((n << 32) / g0);
        b = isqrt((n << 32) / g1);
        rotate(mag, c, s);
        if (s * a <= c * b) begin
          e.along = div_step(a, c);
          e.across = clip((b * c) >> 16);
        end else begin
          e.along = div_step(b, s);
          e.across = clip((a * s) >> 16);
        end
      end
      pending.push_back(e);
    endfunction

    function void report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
      errors++;
      if (errors <= 40)
        $display("MISMATCH %s: expected %h got %h (result %0d)", what, exp_v, got_v, checked);
    endfunction

    // Compare one delivered word with the oldest expectation
    function void check_result(spacing_t got);
      spacing_t e;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 0, got.along);
        return;
      end
      e = pending.pop_front();
      if (got.along !== e.along) report_mismatch("step_along", e.along, got.along);
      if (got.across !== e.across) report_mismatch("step_across", e.across, got.across);
      if (got.fault !== e.fault) report_mismatch("fault", e.fault, got.fault);
    endfunction
  endclass

  localparam int LATENCY = 16 + 50 + 25 + 2 + (25 + 16) + 1;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [31:0] metric_first = '0, metric_second = '0;
  logic signed [17:0] tilt_angle = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [31:0] step_along, step_across;
  logic fault;

  spacing_board board;
  int sender_idle_pct = 30;
  int receiver_idle_pct = 30;
  bit hold_receiver = 1'b0;
  int idle_cycles = 0;
  int items_sent = 0;

  lattice_step_from_metric_unit i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check delivered words and watch for a stuck run
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall)
        board.check_result('{step_along, step_across, fault});
      if ((item_valid && !item_stall) || (result_valid && !result_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("timeout after %0d quiet cycles", idle_cycles);
        $display("lattice_step_from_metric_unit test failed");
        $finish;
      end
    end
  end

  // Stall the result side at random, or hold off on request
  always @(negedge clk) begin
    if (hold_receiver)
      result_stall <= 1'b1;
    else
      result_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  task automatic write_mm(logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_MINIMAL_MATCH);
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.mm = v[15:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offer one word, with a random gap first, and hold it until accepted
  task automatic send_item(logic [31:0] g0, logic [31:0] g1, logic signed [17:0] th);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    metric_first <= g0;
    metric_second <= g1;
    tilt_angle <= th;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.note_item(g0, g1, th);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_metric();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1, 255);
      2: return 32'hFFFF_FFFF - $urandom_range(255);
      default: return 32'(1 << $urandom_range(31)) + $urandom_range(65535);
    endcase
  endfunction

  function automatic logic signed [17:0] rand_angle();
    int m;
    case ($urandom_range(9))
      0: return 18'($urandom);
      1: m = 102943 - $urandom_range(16);
      2: m = $urandom_range(16);
      default: m = $urandom_range(102943);
    endcase
    return $urandom_range(1) ? -18'(m) : 18'(m);
  endfunction

  task automatic random_items(int count);
    logic [31:0] g0;
    for (int k = 0; k < count; k++) begin
      g0 = ($urandom_range(49) == 0) ? 32'd0 : rand_metric();
      send_item(g0, ($urandom_range(49) == 0) ? 32'd0 : rand_metric(), rand_angle());
    end
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, zero angle, fault cases, near-right angles
    send_item(32'h0001_0000, 32'h0001_0000, 18'sd0);
    send_item(32'd1, 32'd1, 18'sd0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 18'sd0);
    send_item(32'd1, 32'hFFFF_FFFF, 18'sd51471);
    send_item(32'hFFFF_FFFF, 32'd1, -18'sd51471);
    send_item(32'd0, 32'h0001_0000, 18'sd100);
    send_item(32'h0001_0000, 32'd0, 18'sd100);
    send_item(32'h0001_0000, 32'h0001_0000, 18'sd102943);
    send_item(32'h0001_0000, 32'h0001_0000, -18'sd102943);
    send_item(32'h0001_0000, 32'h0001_0000, 18'sd102944);
    send_item(32'h0001_0000, 32'h0001_0000, 18'sh20000);
    send_item(32'h0001_0000, 32'h0001_0000, 18'sd131071);
    send_item(32'h0004_0000, 32'h0000_4000, 18'sd1);
    send_item(32'h0000_4000, 32'h0004_0000, -18'sd1);
    send_item(32'hAAAA_5555, 32'h5555_AAAA, 18'sd70000);
    drain();

    // Random with two minimal-match settings, extremes included
    write_mm(32'd1);
    random_items(200);
    drain();
    write_mm(32'hFFFF_FFFF);
    random_items(200);
    drain();

    // Long run with no idling, then a long receiver hold-off
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_mm(32'd32768);
    random_items(300);
    fork
      begin
        hold_receiver = 1'b1;
        repeat (400) @(negedge clk);
        hold_receiver = 1'b0;
      end
      random_items(250);
    join
    drain();
    sender_idle_pct = 30;
    receiver_idle_pct = 30;
    write_mm(32'(MM_RESET));
    random_items(900);
    drain();

    $display("Covered %0d words over four minimal-match settings, incl. fault inputs,",
             items_sent);
    $display("zero and near-right angles, and a long result back-pressure stretch.");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("lattice_step_from_metric_unit test passed");
    else
      $display("lattice_step_from_metric_unit test failed");
    $finish;
  end
endmodule

FILE: lattice_step_from_metric_unit.f
+incdir+hw/rtl
hw/rtl/lsm_pkg.sv
hw/rtl/lsm_cordic_cell.sv
hw/rtl/lsm_div_cell.sv
hw/rtl/lsm_sqrt_cell.sv
hw/rtl/lattice_step_from_metric_unit.sv
bench/lattice_step_from_metric_unit_tb.sv
